// ===== src/gsm7_pkg.sv =====
// gsm7_pkg: shared types, constants and lookup functions for the gsm 7-bit unpacker
// holds the default alphabet table, the extension table and the per-septet step
// no dependencies
`timescale 1ns / 1ps

package gsm7_pkg;

	localparam int SEPTET_W  = 7;
	localparam int BUFFER_W  = 14;
	localparam int HELD_W    = 4;
	localparam int COUNT_W   = 8;
	localparam int CODE_W    = 16;
	localparam int MAX_RES   = 3;
	localparam int RES_CNT_W = 2;

	localparam logic [SEPTET_W-1:0] ESCAPE_SEPTET    = 7'h1B;
	localparam logic [CODE_W-1:0]   REPLACEMENT_CHAR = 16'hFFFD;

	localparam logic [CODE_W-1:0] DEF_ALPHABET [0:127] = '{
		16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
		16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
		16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
		16'h03A3, 16'h0398, 16'h039E, 16'h0000, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
		16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
		16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
		16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
		16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
		16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
		16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
		16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
		16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
		16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
		16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
	};

	typedef struct packed {
		logic [7:0]         data_byte;
		logic               first_byte;
		logic [2:0]         fill_bits;
		logic [COUNT_W-1:0] septet_total;
		logic               last_byte;
	} octet_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_point;
		logic              char_valid;
		logic              message_end;
		logic              run_last;
	} sym_t;

	typedef struct packed {
		logic [BUFFER_W-1:0] bits;
		logic [HELD_W-1:0]   held;
		logic [COUNT_W-1:0]  left;
		logic                esc;
	} dec_state_t;

	typedef struct packed {
		sym_t [MAX_RES-1:0]   res;
		logic [RES_CNT_W-1:0] cnt;
		dec_state_t           next;
	} dec_out_t;

	typedef struct packed {
		logic              emit;
		logic [CODE_W-1:0] code;
		logic              esc;
	} step_t;

	function automatic logic [CODE_W-1:0] ext_lookup(input logic [SEPTET_W-1:0] s);
		logic [CODE_W-1:0] r;
		case (s)
			7'h0A: r = 16'h000C;
			7'h14: r = 16'h005E;
			7'h28: r = 16'h007B;
			7'h29: r = 16'h007D;
			7'h2F: r = 16'h005C;
			7'h3C: r = 16'h005B;
			7'h3D: r = 16'h007E;
			7'h3E: r = 16'h005D;
			7'h40: r = 16'h007C;
			7'h65: r = 16'h20AC;
			default: r = REPLACEMENT_CHAR;
		endcase
		return r;
	endfunction

	function automatic step_t septet_step(input logic esc_in, input logic [SEPTET_W-1:0] s);
		step_t r;
		r = '0;
		if (esc_in) begin
			r.emit = 1'b1;
			r.code = ext_lookup(s);
		end else if (s == ESCAPE_SEPTET) begin
			r.esc = 1'b1;
		end else begin
			r.emit = 1'b1;
			r.code = DEF_ALPHABET[s];
		end
		return r;
	endfunction

endpackage

// ===== src/gsm7_decode.sv =====
// gsm7_decode: combinational unpack and decode of one octet against the held state
// produces up to three result items and the next decoder state
// depends on gsm7_pkg
`timescale 1ns / 1ps

module gsm7_decode (
	input  gsm7_pkg::octet_t     octet,
	input  gsm7_pkg::dec_state_t state,
	output gsm7_pkg::dec_out_t   dec
);

	always_comb begin
		logic                              open_msg;
		logic [2:0]                        skip;
		logic [gsm7_pkg::BUFFER_W-1:0]     base_bits;
		logic [gsm7_pkg::HELD_W-1:0]       base_held;
		logic [gsm7_pkg::COUNT_W-1:0]      left0;
		logic [gsm7_pkg::BUFFER_W+7:0]     merged;
		logic [gsm7_pkg::BUFFER_W-1:0]     bits;
		logic [gsm7_pkg::HELD_W-1:0]       held;
		logic [gsm7_pkg::HELD_W-1:0]       held_after;
		logic                              take0;
		logic                              take1;
		logic                              part;
		logic [1:0]                        ntake;
		logic [gsm7_pkg::COUNT_W-1:0]      left1;
		logic                              ended;
		logic                              esc;
		logic [gsm7_pkg::SEPTET_W-1:0]     sep [gsm7_pkg::MAX_RES];
		logic [gsm7_pkg::MAX_RES-1:0]      use_sep;
		gsm7_pkg::step_t                   st;
		logic [gsm7_pkg::RES_CNT_W-1:0]    cnt;

		open_msg  = octet.first_byte || (state.left != '0);
		skip      = octet.first_byte ? octet.fill_bits : 3'd0;
		base_bits = octet.first_byte ? '0 : state.bits;
		base_held = octet.first_byte ? '0 : state.held;
		left0     = octet.first_byte ? octet.septet_total : state.left;
		esc       = octet.first_byte ? 1'b0 : state.esc;

		merged = {{gsm7_pkg::BUFFER_W{1'b0}}, octet.data_byte >> skip} << base_held;
		bits   = base_bits | merged[gsm7_pkg::BUFFER_W-1:0];
		held   = base_held + (4'd8 - {1'b0, skip});

		take0 = (held >= 4'd7) && (left0 != '0);
		take1 = (held >= 4'd14) && (left0 >= 8'd2);
		ntake = {1'b0, take0} + {1'b0, take1};
		left1 = left0 - {6'd0, ntake};
		held_after = take1 ? held - 4'd14 : (take0 ? held - 4'd7 : held);
		ended = (left1 == '0) || octet.last_byte;
		part  = ended && (left1 != '0) && (held_after != '0);

		sep[0]  = bits[6:0];
		sep[1]  = bits[13:7];
		sep[2]  = take0 ? bits[13:7] : bits[6:0];
		use_sep = {part, take1, take0};

		dec = '0;
		cnt = '0;
		st  = '0;
		for (int k = 0; k < gsm7_pkg::MAX_RES; k++) begin
			if (use_sep[k]) begin
				st = gsm7_pkg::septet_step(esc, sep[k]);
				if (st.emit && cnt != 2'd3) begin
					dec.res[cnt].code_point = st.code;
					dec.res[cnt].char_valid = 1'b1;
					cnt = cnt + 2'd1;
				end
				esc = st.esc;
			end
		end
		if (ended && esc && cnt != 2'd3) begin
			dec.res[cnt].code_point = gsm7_pkg::REPLACEMENT_CHAR;
			dec.res[cnt].char_valid = 1'b1;
			cnt = cnt + 2'd1;
		end
		if (ended && cnt == 2'd0) begin
			dec.res[0].code_point = '0;
			dec.res[0].char_valid = 1'b0;
			cnt = 2'd1;
		end
		for (int k = 0; k < gsm7_pkg::MAX_RES; k++) begin
			dec.res[k].run_last    = (cnt != 2'd0) && (2'(k) == cnt - 2'd1);
			dec.res[k].message_end = ended && (cnt != 2'd0) && (2'(k) == cnt - 2'd1);
		end

		if (!open_msg) begin
			dec.cnt  = '0;
			dec.next = state;
			dec.res  = '0;
		end else if (ended) begin
			dec.cnt  = cnt;
			dec.next = '0;
		end else begin
			dec.cnt       = cnt;
			dec.next.bits = take1 ? '0 : (take0 ? {7'd0, bits[13:7]} : bits);
			dec.next.held = held_after;
			dec.next.left = left1;
			dec.next.esc  = esc;
		end
	end

endmodule

// ===== src/gsm7_septet_unpack_decode.sv =====
// gsm7_septet_unpack_decode: octet input register, combinational decode, result register
// one octet per cycle while unstalled and it yields at most one result
// the three-entry result register drains one result per unstalled cycle, sets the rate
// a new octet is taken while the previous octet's last result is being delivered
// asynchronous active-low reset clears decoder state and empties both registers
// depends on gsm7_pkg and gsm7_decode
`timescale 1ns / 1ps

module gsm7_septet_unpack_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              octet_valid,
	output logic              octet_stall,
	input  gsm7_pkg::octet_t  octet,
	output logic              sym_valid,
	input  logic              sym_stall,
	output gsm7_pkg::sym_t    sym
);

	gsm7_pkg::octet_t                   octet_s1;
	logic                               valid_s1;
	gsm7_pkg::dec_state_t               state_q;
	gsm7_pkg::sym_t [gsm7_pkg::MAX_RES-1:0] res_q;
	logic [gsm7_pkg::RES_CNT_W-1:0]     rem_q;
	gsm7_pkg::dec_out_t                 dec;
	logic                               buf_free;
	logic                               move;
	logic                               octet_take;
	logic                               sym_take;

	gsm7_decode u_decode (
		.octet (octet_s1),
		.state (state_q),
		.dec   (dec)
	);

	assign sym_valid   = (rem_q != '0);
	assign sym         = res_q[0];
	assign sym_take    = sym_valid && !sym_stall;
	assign buf_free    = (rem_q == '0) || ((rem_q == 2'd1) && !sym_stall);
	assign move        = valid_s1 && ((dec.cnt == '0) || buf_free);
	assign octet_stall = valid_s1 && !move;
	assign octet_take  = octet_valid && !octet_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
			rem_q    <= '0;
		end else begin
			valid_s1 <= octet_take || (valid_s1 && !move);
			if (move) begin
				state_q <= dec.next;
			end
			if (move && dec.cnt != '0) begin
				rem_q <= dec.cnt;
			end else if (sym_take) begin
				rem_q <= rem_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (octet_take) begin
			octet_s1 <= octet;
		end
		if (move && dec.cnt != '0) begin
			res_q <= dec.res;
		end else if (sym_take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

`ifndef SYNTH
	a_open_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.left != '0) |-> (state_q.held < 4'd7))
		else $error("open message holds a whole septet");

	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.left == '0) |-> (state_q.held == '0 && !state_q.esc && state_q.bits == '0))
		else $error("closed message left residue");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && sym.message_end) |-> sym.run_last)
		else $error("message end not on last result of octet");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && !sym.char_valid) |-> (sym.code_point == '0 && sym.message_end))
		else $error("bare marker malformed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && dec.cnt != '0 && rem_q > 2'd1) |-> octet_stall)
		else $error("octet moved into occupied result register");
`endif

endmodule

// ===== tb/gsm7_septet_unpack_decode_tb.sv =====
// gsm7_septet_unpack_decode_tb: self-checking bench for the gsm 7-bit septet unpacker
// runs a directed octet table and random messages; typed rows are checked inline, every other
// request against an internal predictor, per symbol; depends on gsm7_pkg and the unpacker rtl
`timescale 1ns / 1ps

module gsm7_septet_unpack_decode_tb;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int RANDOM_OCTETS = 185;
	localparam int HOLD_AFTER    = 20;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 20;
	localparam int REPORT_MAX    = 10;

	localparam logic [15:0] GSM_MAP [0:127] = '{
		16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
		16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
		16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
		16'h03A3, 16'h0398, 16'h039E, 16'h0000, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
		16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
		16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
		16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
		16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
		16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
		16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
		16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
		16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
		16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
		16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
		16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
		16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
	};

	// one directed request; typed rows carry their expected symbol, if any, inline
	typedef struct packed {
		gsm7_pkg::octet_t oct;
		logic             typed;
		logic             has_sym;
		logic [15:0]      code;
		logic             ok;
	} vec_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             octet_valid;
	logic             octet_stall;
	gsm7_pkg::octet_t octet;
	logic             sym_valid;
	logic             sym_stall;
	gsm7_pkg::sym_t   sym;

	// decoder state mirror
	logic [13:0] dec_bits = '0;
	logic [3:0]  dec_held = '0;
	logic [7:0]  dec_left = '0;
	logic [2:0]  dec_skip = '0;
	logic        dec_esc = 1'b0;

	logic [15:0] out_code [0:2];
	logic        out_ok [0:2];
	int          out_n;
	logic        out_end;

	gsm7_pkg::sym_t expected_syms [$];
	vec_t           directed_rows [$];

	int   fails = 0;
	int   cycle_cnt = 0;
	int   octets_sent = 0;
	logic no_gaps = 1'b0;

	gsm7_septet_unpack_decode dut (
		.clk(clk),
		.arst_n(arst_n),
		.octet_valid(octet_valid),
		.octet_stall(octet_stall),
		.octet(octet),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym(sym)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] extension_char(input logic [6:0] s);
		case (s)
			7'h0A: return 16'h000C;
			7'h14: return 16'h005E;
			7'h28: return 16'h007B;
			7'h29: return 16'h007D;
			7'h2F: return 16'h005C;
			7'h3C: return 16'h005B;
			7'h3D: return 16'h007E;
			7'h3E: return 16'h005D;
			7'h40: return 16'h007C;
			7'h65: return 16'h20AC;
			default: return gsm7_pkg::REPLACEMENT_CHAR;
		endcase
	endfunction

	function automatic gsm7_pkg::octet_t mk_octet(input logic [7:0] d, input logic first,
			input logic [2:0] fill, input logic [7:0] total, input logic fin);
		gsm7_pkg::octet_t o;
		o.data_byte    = d;
		o.first_byte   = first;
		o.fill_bits    = fill;
		o.septet_total = total;
		o.last_byte    = fin;
		return o;
	endfunction

	function automatic void add_row(input gsm7_pkg::octet_t o, input logic typed,
			input logic has_sym, input logic [15:0] code, input logic ok);
		vec_t v;
		v.oct     = o;
		v.typed   = typed;
		v.has_sym = has_sym;
		v.code    = code;
		v.ok      = ok;
		directed_rows = {directed_rows, v};
	endfunction

	task automatic emit_char(input logic [15:0] cp, input logic ok);
		if (out_n < 3) begin
			out_code[out_n] = cp;
			out_ok[out_n]   = ok;
			out_n++;
		end
	endtask

	task automatic take_septet(input logic [6:0] s);
		if (dec_esc) begin
			emit_char(extension_char(s), 1'b1);
			dec_esc = 1'b0;
		end else if (s == gsm7_pkg::ESCAPE_SEPTET) begin
			dec_esc = 1'b1;
		end else begin
			emit_char(GSM_MAP[s], 1'b1);
		end
	endtask

	// advances the state mirror by one octet, leaves the symbols in out_code/out_ok
	task automatic decode_octet(input gsm7_pkg::octet_t o);
		logic [21:0] shifted;
		logic        live;
		out_n   = 0;
		out_end = 1'b0;
		live    = o.first_byte || (dec_left != 0);
		if (o.first_byte) begin
			dec_bits = '0;
			dec_held = '0;
			dec_esc  = 1'b0;
			dec_left = o.septet_total;
			dec_skip = o.fill_bits;
		end
		if (live) begin
			shifted  = (22'(o.data_byte) >> dec_skip) << dec_held;
			dec_bits = dec_bits | shifted[13:0];
			dec_held = dec_held + 4'd8 - 4'(dec_skip);
			dec_skip = '0;
			while (dec_held >= 4'd7 && dec_left != 0) begin
				take_septet(dec_bits[6:0]);
				dec_bits = dec_bits >> 7;
				dec_held = dec_held - 4'd7;
				dec_left = dec_left - 8'd1;
			end
			out_end = (dec_left == 0) || o.last_byte;
			if (out_end) begin
				if (dec_left != 0 && dec_held != 0)
					take_septet(dec_bits[6:0]);
				if (dec_esc)
					emit_char(gsm7_pkg::REPLACEMENT_CHAR, 1'b1);
				if (out_n == 0)
					emit_char(16'h0000, 1'b0);
				dec_bits = '0;
				dec_held = '0;
				dec_left = '0;
				dec_esc  = 1'b0;
			end
		end
	endtask

	task automatic send_octet(input vec_t v);
		int             gap;
		int             r;
		gsm7_pkg::sym_t s;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			octet_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		octet       <= v.oct;
		octet_valid <= 1'b1;
		@(posedge clk);
		while (octet_stall) @(posedge clk);
		decode_octet(v.oct);
		if (v.typed) begin
			if (v.has_sym) begin
				s.code_point  = v.code;
				s.char_valid  = v.ok;
				s.message_end = 1'b1;
				s.run_last    = 1'b1;
				expected_syms = {expected_syms, s};
			end
		end else begin
			for (int k = 0; k < out_n; k++) begin
				s.code_point  = out_code[k];
				s.char_valid  = out_ok[k];
				s.message_end = out_end && (k == out_n - 1);
				s.run_last    = (k == out_n - 1);
				expected_syms = {expected_syms, s};
			end
		end
	endtask

	// one packed message, possibly cut short by last_byte or abandoned
	task automatic send_message();
		logic [511:0] stream;
		logic [6:0]   sep;
		logic         esc_open;
		logic         fin;
		int           total;
		int           fill;
		int           n_oct;
		int           stop_at;
		int           shape;
		int           mode;
		vec_t         v;
		for (int w = 0; w < 16; w++)
			stream[32*w +: 32] = $urandom;
		mode = $urandom_range(0, 11);
		if (mode == 0)
			total = 0;
		else if (mode == 1)
			total = $urandom_range(13, 40);
		else
			total = $urandom_range(1, 12);
		fill     = $urandom_range(0, 6);
		esc_open = 1'b0;
		for (int k = 0; k < total; k++) begin
			if (esc_open && $urandom_range(0, 2) != 0) begin
				sep = 7'($urandom_range(0, 127));
				while (extension_char(sep) == gsm7_pkg::REPLACEMENT_CHAR)
					sep = 7'($urandom_range(0, 127));
				esc_open = 1'b0;
			end else if (esc_open) begin
				sep = 7'($urandom_range(0, 127));
				esc_open = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				sep = gsm7_pkg::ESCAPE_SEPTET;
				esc_open = 1'b1;
			end else begin
				sep = 7'($urandom_range(0, 127));
				esc_open = (sep == gsm7_pkg::ESCAPE_SEPTET);
			end
			stream[fill + 7*k +: 7] = sep;
		end
		n_oct   = (total == 0) ? 1 : (fill + 7*total + 7) / 8;
		shape   = $urandom_range(0, 9);
		stop_at = n_oct;
		if (shape == 0)
			stop_at = $urandom_range(1, n_oct);
		else if (shape == 1 && n_oct > 1)
			stop_at = $urandom_range(1, n_oct - 1);
		for (int i = 0; i < stop_at; i++) begin
			if (shape == 0)
				fin = (i == stop_at - 1);
			else if (shape == 1)
				fin = 1'b0;
			else
				fin = (i == stop_at - 1) ? 1'($urandom) : 1'b0;
			v = '0;
			if (i == 0)
				v.oct = mk_octet(stream[7:0], 1'b1, 3'(fill), 8'(total), fin);
			else
				v.oct = mk_octet(stream[8*i +: 8], 1'b0, 3'($urandom_range(0, 6)),
					8'($urandom), fin);
			send_octet(v);
			octets_sent++;
		end
	endtask

	initial begin
		int   msg_cnt;
		vec_t v;
		octet_valid <= 1'b0;
		octet       <= '0;

		add_row(mk_octet(8'hA5, 1'b0, 3'd3, 8'h10, 1'b1), 1'b1, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hFF, 1'b1, 3'd0, 8'h00, 1'b0), 1'b1, 1'b1, 16'h0000, 1'b0);
		add_row(mk_octet(8'h00, 1'b1, 3'd0, 8'h01, 1'b0), 1'b1, 1'b1, 16'h0040, 1'b1);
		add_row(mk_octet(8'hFF, 1'b1, 3'd0, 8'h01, 1'b1), 1'b1, 1'b1, 16'h00E0, 1'b1);
		add_row(mk_octet(8'h1B, 1'b1, 3'd0, 8'h01, 1'b0), 1'b1, 1'b1,
			gsm7_pkg::REPLACEMENT_CHAR, 1'b1);
		add_row(mk_octet(8'h5A, 1'b0, 3'd6, 8'hFF, 1'b1), 1'b1, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hFF, 1'b1, 3'd6, 8'h01, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hFF, 1'b0, 3'd0, 8'h00, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h9B, 1'b1, 3'd0, 8'h02, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h32, 1'b0, 3'd0, 8'h00, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h41, 1'b1, 3'd0, 8'h05, 1'b1), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hFE, 1'b1, 3'd1, 8'h05, 1'b1), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h41, 1'b1, 3'd0, 8'h0A, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h42, 1'b1, 3'd0, 8'h01, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h1B, 1'b1, 3'd0, 8'h02, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h00, 1'b0, 3'd0, 8'h00, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hFF, 1'b1, 3'd0, 8'hFF, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h00, 1'b0, 3'd0, 8'h00, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hAA, 1'b0, 3'd6, 8'h00, 1'b1), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h80, 1'b1, 3'd3, 8'h03, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hFF, 1'b0, 3'd0, 8'h00, 1'b0), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'h55, 1'b0, 3'd0, 8'h00, 1'b1), 1'b0, 1'b0, 16'h0000, 1'b0);
		add_row(mk_octet(8'hC3, 1'b0, 3'd2, 8'h04, 1'b0), 1'b1, 1'b0, 16'h0000, 1'b0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_octet(directed_rows[i]);

		// let everything drain before the random messages
		octet_valid <= 1'b0;
		@(posedge clk);
		while (expected_syms.size() != 0) @(posedge clk);

		msg_cnt = 0;
		while (octets_sent < RANDOM_OCTETS) begin
			if (dec_left == 0 && $urandom_range(0, 9) == 0) begin
				v     = '0;
				v.oct = mk_octet(8'($urandom), 1'b0, 3'($urandom_range(0, 6)), 8'($urandom),
					1'($urandom));
				send_octet(v);
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			if (msg_cnt == 14) begin
				octet_valid <= 1'b0;
				@(posedge clk);
				while (expected_syms.size() != 0) @(posedge clk);
			end
			send_message();
			msg_cnt++;
		end

		octet_valid <= 1'b0;
		@(posedge clk);
		while (expected_syms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fails = fails + expected_syms.size();
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// output stall pattern, with one long hold-off once traffic is flowing
	initial begin : sym_stall_gen
		int   r;
		int   hold_cnt;
		logic hold_done;
		hold_done = 1'b0;
		sym_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (!hold_done && octets_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				sym_stall <= 1'b1;
				hold_cnt = 0;
				while (hold_cnt < HOLD_CYCLES) begin
					@(posedge clk);
					hold_cnt++;
				end
			end else begin
				r = $urandom_range(0, 9);
				if (r < 5) begin
					sym_stall <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else if (r < 9) begin
					sym_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					sym_stall <= 1'b1;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : sym_check
		gsm7_pkg::sym_t want;
		if (arst_n && sym_valid && !sym_stall) begin
			if (expected_syms.size() == 0) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("unexpected symbol: cp=%h valid=%b end=%b run_last=%b",
						sym.code_point, sym.char_valid, sym.message_end, sym.run_last);
			end else begin
				want = expected_syms.pop_front();
				if (sym.code_point !== want.code_point ||
						sym.char_valid !== want.char_valid ||
						sym.message_end !== want.message_end ||
						sym.run_last !== want.run_last) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("symbol mismatch: exp cp=%h valid=%b end=%b run_last=%b, %s",
							want.code_point, want.char_valid, want.message_end,
							want.run_last,
							$sformatf("got cp=%h valid=%b end=%b run_last=%b",
								sym.code_point, sym.char_valid, sym.message_end,
								sym.run_last));
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
